// ----- rtl/ism_pkg.sv -----
// Shared types and constants for the Ising Metropolis site update unit.
// No dependencies; imported by ism_cfg, ism_core and the top level.
package ism_pkg;

  // lattice geometry
  localparam int SITES      = 1024;
  localparam int NEIGHBOURS = 8;
  localparam int SITE_W     = 10;
  localparam int SLOT_W     = 3;
  localparam int NB_ADDR_W  = SITE_W + SLOT_W;
  localparam int NB_DEPTH   = SITES * NEIGHBOURS;
  localparam int NB_ENTRY_W = SITE_W + 1;

  // neighbour scan: one slot per cycle plus the RAM read latency
  localparam int SCAN_LAST = NEIGHBOURS + 1;
  localparam int SCAN_W    = $clog2(SCAN_LAST + 1);

  // sum of up to eight +-1 spins, and the energy change
  localparam int SUM_W = 5;
  localparam int DE_W  = 6;
  localparam int THR_W = 16;
  localparam int RND_W = 16;
  localparam int NUM_THR = 8;

  // stream words
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;

  // configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SET    = 2'd1,
    MODE_UPDATE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_EVAL,
    ST_RESULT
  } state_t;

  // acceptance thresholds, entry i for DE = 2*(i+1)
  typedef struct packed {
    logic [NUM_THR-1:0][THR_W-1:0] thr;
  } cfg_t;

endpackage

// ----- rtl/ism_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ism_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ism_cfg.sv -----
// APB-style register file holding the eight acceptance thresholds.
// Depends on ism_pkg.
module ism_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ism_pkg::PADDR_W-1:0] paddr,
  input  logic [ism_pkg::PDATA_W-1:0] pwdata,
  output logic [ism_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output ism_pkg::cfg_t               cfg
);
  import ism_pkg::*;

  logic [$clog2(NUM_THR)-1:0] idx;
  logic                       wr;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr <= '0;
    end else if (wr) begin
      cfg.thr[idx] <= pwdata[THR_W-1:0];
    end
  end

  // read back
  assign prdata = {{(PDATA_W-THR_W){1'b0}}, cfg.thr[idx]};

endmodule

// ----- rtl/ism_core.sv -----
// Sequencer and datapath: spin store clearing, item decode, neighbour scan
// through one shared accumulator, acceptance test and output register.
// Depends on ism_pkg and ism_ram.
module ism_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ism_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [ism_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ism_pkg::M_TDATA_W-1:0] m_tdata,
  input  ism_pkg::cfg_t                 cfg
);
  import ism_pkg::*;

  localparam logic [SITE_W:0] SITES_EXT  = (SITE_W+1)'(SITES);
  localparam logic [SITE_W-1:0] LAST_SITE = SITE_W'(SITES - 1);
  localparam logic [SLOT_W:0] NB_EXT     = (SLOT_W+1)'(NEIGHBOURS);
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(SCAN_LAST);

  state_t state, state_next;

  // input word fields
  mode_t             in_mode;
  logic [SITE_W-1:0] in_site;
  logic [SLOT_W-1:0] in_slot;
  logic [SITE_W-1:0] in_nsite;
  logic              in_pres;
  logic              in_spin;
  logic [RND_W-1:0]  in_rnd;
  logic              in_range;
  logic              acc;

  assign in_mode  = mode_t'(s_tuser);
  assign in_site  = s_tdata[9:0];
  assign in_slot  = s_tdata[12:10];
  assign in_nsite = s_tdata[22:13];
  assign in_pres  = s_tdata[23];
  assign in_spin  = s_tdata[24];
  assign in_rnd   = s_tdata[40:25];
  assign in_range = {1'b0, in_site} < SITES_EXT;
  assign acc      = s_tvalid && s_tready;

  // working registers
  logic [SITE_W-1:0]       i_site;
  logic [RND_W-1:0]        i_rnd;
  logic [SITE_W-1:0]       clr;
  logic [SCAN_W-1:0]       k;
  logic                    pres_d;
  logic                    site_spin;
  logic signed [SUM_W-1:0] sum;
  logic                    res_spin;
  logic                    res_flip;
  logic signed [DE_W-1:0]  res_de;

  // RAM ports
  logic                  nb_we;
  logic [NB_ENTRY_W-1:0] nb_rdata;
  logic                  sp_we;
  logic [SITE_W-1:0]     sp_waddr;
  logic                  sp_wdata;
  logic [SITE_W-1:0]     sp_raddr;
  logic                  sp_rdata;

  ism_ram #(.WIDTH(NB_ENTRY_W), .DEPTH(NB_DEPTH)) u_nb_ram (
    .clk   (clk),
    .we    (nb_we),
    .waddr ({in_site, in_slot}),
    .wdata ({in_pres, in_nsite}),
    .raddr ({i_site, k[SLOT_W-1:0]}),
    .rdata (nb_rdata)
  );

  ism_ram #(.WIDTH(1), .DEPTH(SITES)) u_spin_ram (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  // shared accumulator: +1 or -1 for a present neighbour
  logic signed [SUM_W-1:0] addend;
  logic signed [SUM_W-1:0] sum_next;
  logic                    nb_ok;

  assign nb_ok    = nb_rdata[SITE_W] && ({1'b0, nb_rdata[SITE_W-1:0]} < SITES_EXT);
  assign addend   = pres_d ? (sp_rdata ? SUM_W'(1) : -SUM_W'(1)) : '0;
  assign sum_next = sum + addend;

  // acceptance test: half energy change is -s*S
  logic signed [SUM_W-1:0] de_half;
  logic [SUM_W-1:0]        de_m1;
  logic signed [DE_W-1:0]  de;
  logic                    flip;

  assign de_half = site_spin ? -sum : sum;
  assign de_m1   = de_half - SUM_W'(1);
  assign de      = {de_half, 1'b0};
  assign flip    = (de_half <= 0) || (i_rnd <= cfg.thr[de_m1[SLOT_W-1:0]]);

  logic out_load;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and RAM controls
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    nb_we      = 1'b0;
    sp_we      = 1'b0;
    sp_waddr   = i_site;
    sp_wdata   = ~site_spin;
    sp_raddr   = i_site;
    out_load   = 1'b0;
    case (state)
      ST_CLEAR: begin
        sp_we    = 1'b1;
        sp_waddr = clr;
        sp_wdata = 1'b1;
        if (clr == LAST_SITE) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        sp_raddr = in_site;
        sp_waddr = in_site;
        sp_wdata = in_spin;
        if (acc) begin
          if (!in_range) begin
            state_next = ST_RESULT;
          end else begin
            case (in_mode)
              MODE_LOAD: begin
                nb_we      = ({1'b0, in_slot} < NB_EXT);
                state_next = ST_READ;
              end
              MODE_SET: begin
                sp_we      = 1'b1;
                state_next = ST_RESULT;
              end
              MODE_UPDATE: state_next = ST_SCAN;
              default:     state_next = ST_READ;
            endcase
          end
        end
      end
      ST_READ: state_next = ST_RESULT;
      ST_SCAN: begin
        sp_raddr = (k == '0) ? i_site : nb_rdata[SITE_W-1:0];
        if (k == SCAN_END) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        sp_we      = flip;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (state == ST_CLEAR) begin
      clr <= clr + SITE_W'(1);
    end
  end

  // scan counter and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (state == ST_SCAN) begin
      k <= k + SCAN_W'(1);
    end else begin
      k <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      pres_d <= nb_ok && (k != '0) && (k != SCAN_END);
      if (k == '0) begin
        sum <= '0;
      end else begin
        sum <= sum_next;
      end
      if (k == SCAN_W'(1)) site_spin <= sp_rdata;
    end else begin
      pres_d <= 1'b0;
    end
  end

  // item latch and result fields
  always_ff @(posedge clk) begin
    if (acc) begin
      i_site   <= in_site;
      i_rnd    <= in_rnd;
      res_flip <= 1'b0;
      res_de   <= '0;
      res_spin <= in_range && in_spin;
    end
    if (state == ST_READ) begin
      res_spin <= sp_rdata;
    end
    if (state == ST_EVAL) begin
      res_spin <= flip ? ~site_spin : site_spin;
      res_flip <= flip;
      res_de   <= flip ? de : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(M_TDATA_W-SITE_W-2-DE_W){1'b0}}, res_de, res_flip, res_spin, i_site};
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("input accepted during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    acc |=> !s_tready)
    else $error("second word accepted while an item is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before it was taken");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && k == SCAN_END) |=> (state == ST_EVAL))
    else $error("neighbour scan did not end after the last slot");
`endif

endmodule

// ----- rtl/ising_metropolis_site_update_unit.sv -----
// Ising Metropolis site update unit, top level: stream ports, APB registers.
// Depends on ism_pkg, ism_cfg, ism_core (and ism_ram through ism_core).
//
// After reset the block sweeps the 1024-entry spin store to all up, one site
// a cycle, and takes no input word during the sweep; register writes are
// taken throughout. It then works on one item at a time. A set word, or one
// whose site is out of range, goes from acceptance straight to the result
// state; a load word or the unused mode passes through a read state first.
// An update runs the neighbour scan, reading one neighbour entry and one spin
// per cycle through a single accumulator over eight slots and the RAM read
// latency, then the evaluate state for the acceptance test and the spin
// write-back, then the result state that loads the output register. A new
// word is accepted as soon as the result has moved to the output register,
// even if it is still waiting there to be taken.
// Thresholds sit at byte addresses 0x00 (DE 2) to 0x1C (DE 16).
module ising_metropolis_site_update_unit (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [9:0] site, [12:10] slot, [22:13] neighbour_site, [23] neighbour_present,
  // [24] spin_in, [40:25] random_value, [47:41] zero
  input  logic [ism_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] mode
  input  logic [ism_pkg::S_TUSER_W-1:0] s_tuser,
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [9:0] site_out, [10] spin_out, [11] flipped, [17:12] energy_change,
  // [23:18] zero
  output logic [ism_pkg::M_TDATA_W-1:0] m_tdata,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ism_pkg::PADDR_W-1:0]   paddr,
  input  logic [ism_pkg::PDATA_W-1:0]   pwdata,
  output logic [ism_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ism_pkg::*;

  cfg_t cfg;

  ism_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ism_core u_core (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg      (cfg)
  );

endmodule

// ----- tb/ising_metropolis_site_update_unit_test.sv -----
// Self-checking testbench for the Ising Metropolis site update unit.
// Depends on ism_pkg and the ising_metropolis_site_update_unit RTL; a scoreboard class
// predicts every result word from its own copy of the lattice and the thresholds.
`timescale 1ns / 1ps

module ising_metropolis_site_update_unit_test;
  import ism_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int POOL_N = 12;

  // one input word, fields unpacked
  typedef struct {
    logic [1:0]        mode;
    logic [SITE_W-1:0] site;
    logic [SLOT_W-1:0] slot;
    logic [SITE_W-1:0] nb_site;
    logic              nb_present;
    logic              spin_in;
    logic [RND_W-1:0]  rnd;
  } site_word_t;

  // one expected result word
  typedef struct {
    logic [SITE_W-1:0]      site;
    logic                   spin;
    logic                   flipped;
    logic signed [DE_W-1:0] de;
  } site_result_t;

  // Lattice predictor and result store
  class site_update_scoreboard;
    bit                  spin_mem [SITES];
    bit [NB_ENTRY_W-1:0] nb_mem [NB_DEPTH];
    bit [THR_W-1:0]      thr [NUM_THR];
    site_result_t        result_q [$];
    int errors, n_load, n_set, n_update, n_uphill, n_reject, n_other;

    function new();
      foreach (spin_mem[i]) spin_mem[i] = 1'b1;
    endfunction

    function void report(string msg);
      if (errors < 40) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    // work out the result of an accepted word and update the lattice
    function void note_word(site_word_t w);
      site_result_t        r;
      int                  sum;
      int                  s;
      int                  de;
      int                  base;
      bit                  flip;
      bit [NB_ENTRY_W-1:0] e;
      r.site    = w.site;
      r.flipped = 1'b0;
      r.de      = '0;
      case (w.mode)
        MODE_LOAD: begin
          nb_mem[w.site * NEIGHBOURS + w.slot] = {w.nb_present, w.nb_site};
          r.spin = spin_mem[w.site];
          n_load++;
        end
        MODE_SET: begin
          spin_mem[w.site] = w.spin_in;
          r.spin = w.spin_in;
          n_set++;
        end
        MODE_UPDATE: begin
          sum  = 0;
          s    = spin_mem[w.site] ? 1 : -1;
          base = w.site * NEIGHBOURS;
          // self neighbour sees the spin before the flip
          for (int k = 0; k < NEIGHBOURS; k++) begin
            e = nb_mem[base + k];
            if (e[SITE_W] && e[SITE_W-1:0] < SITES)
              sum += spin_mem[e[SITE_W-1:0]] ? 1 : -1;
          end
          de = -2 * s * sum;
          if (de <= 0) flip = 1'b1;
          else flip = (w.rnd <= thr[de / 2 - 1]);
          if (flip) begin
            spin_mem[w.site] = !spin_mem[w.site];
            r.flipped = 1'b1;
            r.de      = DE_W'(de);
            if (de > 0) n_uphill++;
          end else begin
            n_reject++;
          end
          r.spin = spin_mem[w.site];
          n_update++;
        end
        default: begin
          r.spin = spin_mem[w.site];
          n_other++;
        end
      endcase
      result_q = {result_q, r};
    endfunction

    // compare a taken result word with the oldest expectation
    function void check_word(logic [M_TDATA_W-1:0] d);
      site_result_t r;
      if (result_q.size() == 0) begin
        report($sformatf("result word %h with nothing expected", d));
        return;
      end
      r = result_q.pop_front();
      if (d[9:0] !== r.site)
        report($sformatf("site_out %0d, expected %0d", d[9:0], r.site));
      if (d[10] !== r.spin)
        report($sformatf("site %0d spin_out %b, expected %b", r.site, d[10], r.spin));
      if (d[11] !== r.flipped)
        report($sformatf("site %0d flipped %b, expected %b", r.site, d[11], r.flipped));
      if (d[17:12] !== r.de)
        report($sformatf("site %0d energy_change %0d, expected %0d", r.site,
                         $signed(d[17:12]), r.de));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic [S_TUSER_W-1:0]  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  site_update_scoreboard  sb = new();
  bit [NEIGHBOURS-1:0]    slots_loaded [SITES];
  logic [SITE_W-1:0]      pool [POOL_N];
  int                     words_sent;
  bit                     src_burst;
  bit                     sink_hold;

  ising_metropolis_site_update_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic site_word_t word(logic [1:0] mode, logic [SITE_W-1:0] site,
                                      logic [SLOT_W-1:0] slot, logic [SITE_W-1:0] nb_site,
                                      logic nb_present, logic spin_in, logic [RND_W-1:0] rnd);
    site_word_t w;
    w.mode       = mode;
    w.site       = site;
    w.slot       = slot;
    w.nb_site    = nb_site;
    w.nb_present = nb_present;
    w.spin_in    = spin_in;
    w.rnd        = rnd;
    return w;
  endfunction

  // offer one word after a random gap and wait for it to be taken
  task automatic put_word(input site_word_t w);
    int gap;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.mode;
    s_tdata  <= {7'd0, w.rnd, w.spin_in, w.nb_present, w.nb_site, w.slot, w.site};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.note_word(w);
    if (w.mode == MODE_LOAD) slots_loaded[w.site][w.slot] = 1'b1;
    words_sent++;
  endtask

  // write all eight thresholds, psel held across the batch
  task automatic load_thresholds(input logic [NUM_THR-1:0][THR_W-1:0] tbl);
    for (int i = 0; i < NUM_THR; i++) begin
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'(4 * i);
      pwdata  <= PDATA_W'(tbl[i]);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (pready !== 1'b1) @(posedge clk);
      sb.thr[i] = tbl[i];
      penable <= 1'b0;
    end
    psel   <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // stop offering, let every expected word arrive, then a latency's worth more
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic site_word_t random_word();
    site_word_t w;
    w.mode       = 2'($urandom_range(0, 3));
    w.site       = SITE_W'($urandom);
    w.slot       = SLOT_W'($urandom);
    w.nb_site    = SITE_W'($urandom);
    w.nb_present = 1'($urandom);
    w.spin_in    = 1'($urandom);
    w.rnd        = RND_W'($urandom);
    return w;
  endfunction

  // up to half updates over a small fully loaded lattice, plus loads, sets and noise
  task automatic random_step();
    site_word_t        w;
    int                pick;
    logic [SITE_W-1:0] target;
    w      = random_word();
    pick   = $urandom_range(0, 99);
    target = pool[$urandom_range(0, POOL_N - 1)];
    if (pick < 50) begin
      if (slots_loaded[target] != '1) begin
        // finish the site's neighbour list before it may be updated
        w.mode    = MODE_LOAD;
        w.site    = target;
        w.nb_site = pool[$urandom_range(0, POOL_N - 1)];
        w.nb_present = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < NEIGHBOURS; k++) begin
          if (!slots_loaded[target][k]) begin
            w.slot = SLOT_W'(k);
            break;
          end
        end
      end else begin
        w.mode = MODE_UPDATE;
        w.site = target;
        if ($urandom_range(0, 3) == 0)
          w.rnd = sb.thr[$urandom_range(0, NUM_THR - 1)] + RND_W'($urandom_range(0, 1));
      end
    end else if (pick < 70) begin
      w.mode = MODE_LOAD;
      w.site = target;
      if ($urandom_range(0, 4) != 0) w.nb_site = pool[$urandom_range(0, POOL_N - 1)];
    end else if (pick < 85) begin
      w.mode = MODE_SET;
      if ($urandom_range(0, 9) < 7) w.site = target;
    end else if (pick < 90) begin
      w.mode = MODE_UNUSED;
    end else begin
      // load anywhere in the lattice
      w.mode = MODE_LOAD;
    end
    put_word(w);
  endtask

  // result side: random stalls, burst stretches, one long hold-off
  initial begin : result_sink
    int gap;
    bit sink_burst;
    m_tready <= 1'b0;
    gap = 0;
    sink_burst = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
        sb.check_word(m_tdata);
        if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
        gap = sink_burst ? 0 : $urandom_range(0, 14);
      end
      if (sink_hold || gap > 0) begin
        m_tready <= 1'b0;
        if (gap > 0) gap--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // long output stall while the sender keeps offering
  initial begin : output_hold
    wait (words_sent >= 60);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (300) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout: %0d words sent, %0d results outstanding", words_sent, sb.pending());
    $display("ising_metropolis_site_update_unit_test failed");
    $finish;
  end

  initial begin : stimulus
    logic [NUM_THR-1:0][THR_W-1:0] tbl;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    pool[0] = '0;
    pool[1] = '1;
    pool[2] = 10'h155;
    pool[3] = 10'h2AA;
    for (int i = 4; i < POOL_N; i++) pool[i] = SITE_W'($urandom);

    // written while the spin store is still being cleared
    tbl[0] = 16'h0000; tbl[1] = 16'hFFFF; tbl[2] = 16'h0001; tbl[3] = 16'h8000;
    tbl[4] = 16'h1234; tbl[5] = 16'hFFFF; tbl[6] = 16'h0000; tbl[7] = 16'hFFFE;
    load_thresholds(tbl);

    // directed: unused mode, set, self neighbour, empty slot, threshold edges
    put_word(word(MODE_UNUSED, 10'h3FF, 3'd7, 10'h3FF, 1'b1, 1'b1, 16'h0000));
    put_word(word(MODE_SET, 10'h3FF, 3'd0, 10'h000, 1'b0, 1'b0, 16'hFFFF));
    for (int k = 0; k < NEIGHBOURS; k++)
      put_word(word(MODE_LOAD, 10'h000, SLOT_W'(k), (k == 1) ? 10'h000 : 10'h3FF,
                    k != 2, 1'b0, 16'h0000));
    // site 0 sees DE 10: one above the threshold rejects, equal accepts
    put_word(word(MODE_UPDATE, 10'h000, 3'd0, 10'h000, 1'b0, 1'b0, 16'h1235));
    put_word(word(MODE_UPDATE, 10'h000, 3'd0, 10'h000, 1'b0, 1'b0, 16'h1234));
    put_word(word(MODE_UPDATE, 10'h000, 3'd7, 10'h3FF, 1'b1, 1'b1, 16'hFFFF));
    // all slots empty: zero energy change always flips
    for (int k = 0; k < NEIGHBOURS; k++)
      put_word(word(MODE_LOAD, 10'h3FF, SLOT_W'(k), (k % 2) ? 10'h3FF : 10'h000,
                    1'b0, 1'b1, 16'hFFFF));
    put_word(word(MODE_UPDATE, 10'h3FF, 3'd0, 10'h000, 1'b0, 1'b0, 16'h0000));
    put_word(word(MODE_SET, 10'h000, 3'd7, 10'h3FF, 1'b1, 1'b0, 16'h0000));
    put_word(word(MODE_UNUSED, 10'h000, 3'd0, 10'h000, 1'b0, 1'b1, 16'hFFFF));
    drain();

    // random phases, each under its own threshold table
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < NUM_THR; i++) begin
        case (phase)
          0: tbl[i] = 16'hFFFF;
          1: tbl[i] = 16'h0000;
          2: tbl[i] = 16'($urandom);
          default: tbl[i] = 16'h0;
        endcase
      end
      if (phase == 3) begin
        // exp(-DE/2) scaled by 65536
        tbl[0] = 16'd24109; tbl[1] = 16'd8869; tbl[2] = 16'd3263; tbl[3] = 16'd1200;
        tbl[4] = 16'd441;   tbl[5] = 16'd162;  tbl[6] = 16'd60;   tbl[7] = 16'd22;
      end
      load_thresholds(tbl);
      repeat (100) random_step();
      drain();
    end

    $display("covered %0d words: %0d updates, %0d uphill flips accepted, %0d rejected",
             words_sent, sb.n_update, sb.n_uphill, sb.n_reject);
    $display("%0d neighbour loads, %0d spin sets, %0d unused-mode words, 5 threshold tables",
             sb.n_load, sb.n_set, sb.n_other);
    if (sb.errors == 0)
      $display("ising_metropolis_site_update_unit_test passed");
    else
      $display("ising_metropolis_site_update_unit_test failed");
    $finish;
  end

endmodule
